// ===== hw/rtl/bki_pkg.sv =====
`timescale 1ns / 1ps
package bki_pkg;

  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 33;

  localparam logic [30:0] Margin     = 31'd66;
  localparam logic [16:0] OneQ16     = 17'd65536;

  typedef enum logic [2:0] {
    CFG_FORCE_MAX  = 3'd0,
    CFG_FORCE_MIN  = 3'd1,
    CFG_SPEED_MAX  = 3'd2,
    CFG_TIME_STEP  = 3'd3,
    CFG_WORLD_W    = 3'd4,
    CFG_WORLD_H    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [30:0] force_max;
    logic [30:0] force_min;
    logic [30:0] speed_max;
    logic [16:0] dt;
    logic [30:0] world_w;
    logic [30:0] world_h;
  } cfg_t;

  // squared magnitude of a 2-d vector of signed 33-bit components
  function automatic logic [65:0] sq_mag(input logic signed [32:0] x,
                                         input logic signed [32:0] y);
    logic [32:0] ax;
    logic [32:0] ay;
    ax = x[32] ? 33'(-x) : 33'(x);
    ay = y[32] ? 33'(-y) : 33'(y);
    return 66'(ax * ax) + 66'(ay * ay);
  endfunction

endpackage

// ===== hw/rtl/bki_isqrt.sv =====
`timescale 1ns / 1ps
// pipelined integer square root, one result bit per stage
module bki_isqrt import bki_pkg::*; (
  input  logic        clk,
  input  logic [65:0] n_in,
  output logic [32:0] root_out
);

  logic [65:0] rem_r  [SqrtSteps+1];
  logic [32:0] root_r [SqrtSteps+1];

  always_comb begin
    rem_r[0]  = n_in;
    root_r[0] = '0;
  end

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_st
    localparam int unsigned Sh = 2 * (SqrtSteps - 1 - i);
    logic [65:0] trial;
    logic [65:0] rem_nxt;
    logic [32:0] root_nxt;
    always_comb begin
      trial    = (66'(root_r[i]) << (Sh + 2)) | (66'd1 << Sh);
      rem_nxt  = rem_r[i];
      root_nxt = root_r[i] << 1;
      if (rem_r[i] >= trial) begin
        rem_nxt  = rem_r[i] - trial;
        root_nxt = (root_r[i] << 1) | 33'd1;
      end
    end
    always_ff @(posedge clk) begin
      rem_r[i+1]  <= rem_nxt;
      root_r[i+1] <= root_nxt;
    end
  end

  assign root_out = root_r[SqrtSteps];

endmodule

// ===== hw/rtl/bki_div.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider, unsigned 64 / 33, one quotient bit per stage
module bki_div import bki_pkg::*; (
  input  logic        clk,
  input  logic [63:0] num_in,
  input  logic [32:0] den_in,
  output logic [32:0] quo_out
);

  logic [63:0] rem_r [DivSteps+1];
  logic [32:0] den_r [DivSteps+1];
  logic [32:0] quo_r [DivSteps+1];

  always_comb begin
    rem_r[0] = num_in;
    den_r[0] = den_in;
    quo_r[0] = '0;
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_st
    localparam int unsigned Sh = DivSteps - 1 - i;
    logic [96:0] trial;
    logic [63:0] rem_nxt;
    logic [32:0] quo_nxt;
    always_comb begin
      trial   = 97'(den_r[i]) << Sh;
      rem_nxt = rem_r[i];
      quo_nxt = quo_r[i] << 1;
      if (97'(rem_r[i]) >= trial) begin
        rem_nxt = rem_r[i] - trial[63:0];
        quo_nxt = (quo_r[i] << 1) | 33'd1;
      end
    end
    always_ff @(posedge clk) begin
      rem_r[i+1] <= rem_nxt;
      den_r[i+1] <= den_r[i];
      quo_r[i+1] <= quo_nxt;
    end
  end

  assign quo_out = quo_r[DivSteps];

endmodule

// ===== hw/rtl/bki_clamp.sv =====
`timescale 1ns / 1ps
// magnitude clamp: rescales (x,y) to lim when longer
module bki_clamp import bki_pkg::*; (
  input  logic               clk,
  input  logic signed [32:0] x_in,
  input  logic signed [32:0] y_in,
  input  logic [30:0]        lim_in,
  output logic signed [32:0] x_out,
  output logic signed [32:0] y_out
);

  logic [65:0]        sq_r;
  logic signed [32:0] x0_r, y0_r;
  logic [30:0]        lim0_r;
  logic [32:0]        len;
  logic signed [32:0] xd_r [SqrtSteps+1];
  logic signed [32:0] yd_r [SqrtSteps+1];
  logic [30:0]        ld_r [SqrtSteps+1];
  logic               ov_r [SqrtSteps+1];

  always_ff @(posedge clk) begin
    sq_r   <= sq_mag(x_in, y_in);
    x0_r   <= x_in;
    y0_r   <= y_in;
    lim0_r <= lim_in;
  end

  bki_isqrt u_sqrt (.clk(clk), .n_in(sq_r), .root_out(len));

  always_comb begin
    xd_r[0] = x0_r;
    yd_r[0] = y0_r;
    ld_r[0] = lim0_r;
    ov_r[0] = sq_r > 66'(62'(lim0_r) * 62'(lim0_r));
  end
  for (genvar i = 0; i < SqrtSteps; i++) begin : g_d
    always_ff @(posedge clk) begin
      xd_r[i+1] <= xd_r[i];
      yd_r[i+1] <= yd_r[i];
      ld_r[i+1] <= ld_r[i];
      ov_r[i+1] <= ov_r[i];
    end
  end

  // products |c| * lim, registered
  logic [63:0]        px_r, py_r;
  logic               sx_r, sy_r, ov1_r, lz_r;
  logic [32:0]        len_r;
  logic signed [32:0] xo_r, yo_r;
  logic [32:0]        ax, ay;
  always_comb begin
    ax = xd_r[SqrtSteps][32] ? 33'(-xd_r[SqrtSteps]) : 33'(xd_r[SqrtSteps]);
    ay = yd_r[SqrtSteps][32] ? 33'(-yd_r[SqrtSteps]) : 33'(yd_r[SqrtSteps]);
  end
  always_ff @(posedge clk) begin
    px_r  <= 64'(ax * 64'(ld_r[SqrtSteps]));
    py_r  <= 64'(ay * 64'(ld_r[SqrtSteps]));
    sx_r  <= xd_r[SqrtSteps][32];
    sy_r  <= yd_r[SqrtSteps][32];
    ov1_r <= ov_r[SqrtSteps];
    lz_r  <= len == '0;
    len_r <= (len == '0) ? 33'd1 : len;
    xo_r  <= xd_r[SqrtSteps];
    yo_r  <= yd_r[SqrtSteps];
  end

  logic [32:0] qx, qy;
  bki_div u_dx (.clk(clk), .num_in(px_r), .den_in(len_r), .quo_out(qx));
  bki_div u_dy (.clk(clk), .num_in(py_r), .den_in(len_r), .quo_out(qy));

  logic               sx_d [DivSteps+1];
  logic               sy_d [DivSteps+1];
  logic               ov_d [DivSteps+1];
  logic               lz_d [DivSteps+1];
  logic signed [32:0] xo_d [DivSteps+1];
  logic signed [32:0] yo_d [DivSteps+1];
  always_comb begin
    sx_d[0] = sx_r; sy_d[0] = sy_r; ov_d[0] = ov1_r; lz_d[0] = lz_r;
    xo_d[0] = xo_r; yo_d[0] = yo_r;
  end
  for (genvar i = 0; i < DivSteps; i++) begin : g_e
    always_ff @(posedge clk) begin
      sx_d[i+1] <= sx_d[i]; sy_d[i+1] <= sy_d[i];
      ov_d[i+1] <= ov_d[i]; lz_d[i+1] <= lz_d[i];
      xo_d[i+1] <= xo_d[i]; yo_d[i+1] <= yo_d[i];
    end
  end

  always_comb begin
    x_out = xo_d[DivSteps];
    y_out = yo_d[DivSteps];
    if (ov_d[DivSteps]) begin
      if (lz_d[DivSteps]) begin
        x_out = '0;
        y_out = '0;
      end else begin
        x_out = sx_d[DivSteps] ? 33'(-qx) : 33'(qx);
        y_out = sy_d[DivSteps] ? 33'(-qy) : 33'(qy);
      end
    end
  end

endmodule

// ===== hw/rtl/boid_kinematic_integrate_top.sv =====
`timescale 1ns / 1ps
// channel  | ports                                   | direction
// input    | start, busy, in_accel/vel/pos x,y       | in (busy low)
// result   | out_valid, out_new_vel/pos, out_color_* | out, one cycle strobe
// config   | cfg_we, cfg_index, cfg_data             | in, immediate write
// one transfer enters per cycle and its result leaves in input order
// path: force clamp, 3 integrate stages, speed clamp, 1 position stage, color root,
// 1 segment stage, ramp divide, 1 output register; each clamp is register, root, register, divide
// rst_n is synchronous, clears the valid bits and loads the config defaults; busy is always low
// the receiver cannot stall, so the pipeline never holds
module boid_kinematic_integrate_top import bki_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_accel_x,
  input  logic signed [31:0] in_accel_y,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  output logic               out_valid,
  output logic signed [31:0] out_new_vel_x,
  output logic signed [31:0] out_new_vel_y,
  output logic signed [31:0] out_new_pos_x,
  output logic signed [31:0] out_new_pos_y,
  output logic [7:0]         out_color_red,
  output logic [7:0]         out_color_green,
  output logic [7:0]         out_color_blue
);

  localparam int unsigned CL = SqrtSteps + DivSteps + 2;  // clamp latency

  cfg_t cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.force_max <= 31'd65536;
      cfg_r.force_min <= 31'd0;
      cfg_r.speed_max <= 31'd262144;
      cfg_r.dt        <= 17'd1092;
      cfg_r.world_w   <= 31'd52428800;
      cfg_r.world_h   <= 31'd39321600;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FORCE_MAX: cfg_r.force_max <= cfg_data;
        CFG_FORCE_MIN: cfg_r.force_min <= cfg_data;
        CFG_SPEED_MAX: cfg_r.speed_max <= cfg_data;
        CFG_TIME_STEP: cfg_r.dt        <= cfg_data[16:0];
        CFG_WORLD_W:   cfg_r.world_w   <= cfg_data;
        CFG_WORLD_H:   cfg_r.world_h   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  logic in_fire;
  assign in_fire = start && !busy;

  logic [16:0] dt;
  assign dt = (cfg_r.dt > OneQ16) ? OneQ16 : cfg_r.dt;

  // stage a: force clamp
  logic signed [32:0] ac_x, ac_y;
  bki_clamp u_fclamp (.clk(clk), .x_in(33'(in_accel_x)), .y_in(33'(in_accel_y)),
    .lim_in(cfg_r.force_max), .x_out(ac_x), .y_out(ac_y));

  logic               va_r [CL+1];
  logic signed [31:0] vxa_r [CL+1];
  logic signed [31:0] vya_r [CL+1];
  logic signed [31:0] pxa_r [CL+1];
  logic signed [31:0] pya_r [CL+1];
  always_comb begin
    va_r[0] = in_fire; vxa_r[0] = in_vel_x; vya_r[0] = in_vel_y;
    pxa_r[0] = in_pos_x; pya_r[0] = in_pos_y;
  end
  for (genvar i = 0; i < CL; i++) begin : g_a
    always_ff @(posedge clk) begin
      if (!rst_n) va_r[i+1] <= 1'b0;
      else        va_r[i+1] <= va_r[i];
      vxa_r[i+1] <= vxa_r[i]; vya_r[i+1] <= vya_r[i];
      pxa_r[i+1] <= pxa_r[i]; pya_r[i+1] <= pya_r[i];
    end
  end

  // minimum test and scaled increment, registered after each multiply
  logic signed [32:0] am_x, am_y;
  logic               vb_r;
  logic signed [31:0] vxb_r, vyb_r, pxb_r, pyb_r;
  logic signed [32:0] amx_r, amy_r;
  always_comb begin
    am_x = ac_x; am_y = ac_y;
    if (sq_mag(ac_x, ac_y) < 66'(62'(cfg_r.force_min) * 62'(cfg_r.force_min))) begin
      am_x = '0; am_y = '0;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else        vb_r <= va_r[CL];
    amx_r <= am_x; amy_r <= am_y;
    vxb_r <= vxa_r[CL]; vyb_r <= vya_r[CL]; pxb_r <= pxa_r[CL]; pyb_r <= pya_r[CL];
  end

  logic signed [50:0] mx_r, my_r;
  logic               vc_r;
  logic signed [31:0] vxc_r, vyc_r, pxc_r, pyc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else        vc_r <= vb_r;
    mx_r <= 51'(amx_r * $signed({1'b0, dt}));
    my_r <= 51'(amy_r * $signed({1'b0, dt}));
    vxc_r <= vxb_r; vyc_r <= vyb_r; pxc_r <= pxb_r; pyc_r <= pyb_r;
  end

  function automatic logic signed [34:0] tdiv16(input logic signed [50:0] v);
    logic signed [50:0] a;
    a = v[50] ? v + 51'sd65535 : v;
    return 35'(a >>> 16);
  endfunction

  function automatic logic signed [32:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647)  return 33'sd2147483647;
    if (v < -35'sd2147483648) return -33'sd2147483648;
    return 33'(v);
  endfunction

  logic signed [32:0] vi_x, vi_y;
  assign vi_x = sat32(35'(vxc_r) + tdiv16(mx_r));
  assign vi_y = sat32(35'(vyc_r) + tdiv16(my_r));

  // saturated velocity registered ahead of the speed clamp
  logic               vv_r;
  logic signed [32:0] vix_r, viy_r;
  logic signed [31:0] pxv_r, pyv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vv_r <= 1'b0;
    else        vv_r <= vc_r;
    vix_r <= vi_x; viy_r <= vi_y;
    pxv_r <= pxc_r; pyv_r <= pyc_r;
  end

  logic signed [32:0] vs_x, vs_y;
  bki_clamp u_vclamp (.clk(clk), .x_in(vix_r), .y_in(viy_r),
    .lim_in(cfg_r.speed_max), .x_out(vs_x), .y_out(vs_y));

  logic               vd_r [CL+1];
  logic signed [31:0] pxd_r [CL+1];
  logic signed [31:0] pyd_r [CL+1];
  always_comb begin
    vd_r[0] = vv_r; pxd_r[0] = pxv_r; pyd_r[0] = pyv_r;
  end
  for (genvar i = 0; i < CL; i++) begin : g_d
    always_ff @(posedge clk) begin
      if (!rst_n) vd_r[i+1] <= 1'b0;
      else        vd_r[i+1] <= vd_r[i];
      pxd_r[i+1] <= pxd_r[i]; pyd_r[i+1] <= pyd_r[i];
    end
  end

  // position integrate
  logic               ve_r;
  logic signed [50:0] nx_r, ny_r;
  logic signed [31:0] vfx_r, vfy_r, pxe_r, pye_r;
  logic [65:0]        ssq_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ve_r <= 1'b0;
    else        ve_r <= vd_r[CL];
    nx_r  <= 51'(vs_x * $signed({1'b0, dt}));
    ny_r  <= 51'(vs_y * $signed({1'b0, dt}));
    vfx_r <= vs_x[31:0]; vfy_r <= vs_y[31:0];
    pxe_r <= pxd_r[CL]; pye_r <= pyd_r[CL];
    ssq_r <= sq_mag(vs_x, vs_y);
  end

  // world smaller than the margin pins the far side to zero
  function automatic logic [31:0] wclamp(input logic signed [34:0] p,
                                         input logic [30:0] edge_v);
    if (p < 0) return '0;
    if (p >= $signed({4'd0, edge_v})) return (edge_v >= Margin) ? 32'(edge_v - Margin) : '0;
    return 32'(p);
  endfunction

  logic [31:0] npx, npy;
  assign npx = wclamp(35'(pxe_r) + tdiv16(nx_r), cfg_r.world_w);
  assign npy = wclamp(35'(pye_r) + tdiv16(ny_r), cfg_r.world_h);

  // speed root and ramp divide
  logic [32:0] spd;
  bki_isqrt u_ssqrt (.clk(clk), .n_in(ssq_r), .root_out(spd));

  logic               vf_r [SqrtSteps+1];
  logic [31:0]        rvx_r [SqrtSteps+1];
  logic [31:0]        rvy_r [SqrtSteps+1];
  logic [31:0]        rpx_r [SqrtSteps+1];
  logic [31:0]        rpy_r [SqrtSteps+1];
  always_comb begin
    vf_r[0] = ve_r; rvx_r[0] = vfx_r; rvy_r[0] = vfy_r; rpx_r[0] = npx; rpy_r[0] = npy;
  end
  for (genvar i = 0; i < SqrtSteps; i++) begin : g_f
    always_ff @(posedge clk) begin
      if (!rst_n) vf_r[i+1] <= 1'b0;
      else        vf_r[i+1] <= vf_r[i];
      rvx_r[i+1] <= rvx_r[i]; rvy_r[i+1] <= rvy_r[i];
      rpx_r[i+1] <= rpx_r[i]; rpy_r[i+1] <= rpy_r[i];
    end
  end

  // segment select
  logic [34:0] s4, s2, m3;
  logic [1:0]  seg;
  logic [63:0] rnum;
  logic [42:0] num, base;
  always_comb begin
    s4 = 35'(spd) << 2;
    s2 = 35'(spd) << 1;
    m3 = 35'(cfg_r.speed_max) * 35'd3;
    if (s4 <= 35'(cfg_r.speed_max))      seg = 2'd0;
    else if (s2 <= 35'(cfg_r.speed_max)) seg = 2'd1;
    else if (s4 <= m3)                   seg = 2'd2;
    else                                 seg = 2'd3;
    num  = 43'(spd) * 43'd1020;
    base = 43'(cfg_r.speed_max) * 43'd255 * 43'(seg);
    rnum = (num <= base) ? '0 : 64'(num - base);
  end

  logic               vg_r;
  logic [63:0]        rnum_r;
  logic [1:0]         seg_r;
  logic               mz_r;
  logic [31:0]        gvx_r, gvy_r, gpx_r, gpy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vg_r <= 1'b0;
    else        vg_r <= vf_r[SqrtSteps];
    rnum_r <= rnum; seg_r <= seg; mz_r <= cfg_r.speed_max == '0;
    gvx_r <= rvx_r[SqrtSteps]; gvy_r <= rvy_r[SqrtSteps];
    gpx_r <= rpx_r[SqrtSteps]; gpy_r <= rpy_r[SqrtSteps];
  end

  logic [32:0] q;
  bki_div u_rdiv (.clk(clk), .num_in(rnum_r), .den_in(mz_r ? 33'd1 : 33'(cfg_r.speed_max)),
    .quo_out(q));

  logic        vh_r [DivSteps+1];
  logic [1:0]  sh_r [DivSteps+1];
  logic        mh_r [DivSteps+1];
  logic [31:0] hvx_r [DivSteps+1];
  logic [31:0] hvy_r [DivSteps+1];
  logic [31:0] hpx_r [DivSteps+1];
  logic [31:0] hpy_r [DivSteps+1];
  always_comb begin
    vh_r[0] = vg_r; sh_r[0] = seg_r; mh_r[0] = mz_r;
    hvx_r[0] = gvx_r; hvy_r[0] = gvy_r; hpx_r[0] = gpx_r; hpy_r[0] = gpy_r;
  end
  for (genvar i = 0; i < DivSteps; i++) begin : g_h
    always_ff @(posedge clk) begin
      if (!rst_n) vh_r[i+1] <= 1'b0;
      else        vh_r[i+1] <= vh_r[i];
      sh_r[i+1] <= sh_r[i]; mh_r[i+1] <= mh_r[i];
      hvx_r[i+1] <= hvx_r[i]; hvy_r[i+1] <= hvy_r[i];
      hpx_r[i+1] <= hpx_r[i]; hpy_r[i+1] <= hpy_r[i];
    end
  end

  logic [7:0] qs, r_nxt, g_nxt, b_nxt;
  always_comb begin
    qs = (q > 33'd255) ? 8'd255 : q[7:0];
    r_nxt = 8'd255; g_nxt = 8'd0; b_nxt = 8'd0;
    if (!mh_r[DivSteps]) begin
      case (sh_r[DivSteps])
        2'd0:    begin r_nxt = 8'd0;   g_nxt = qs;          b_nxt = 8'd255; end
        2'd1:    begin r_nxt = 8'd0;   g_nxt = 8'd255;      b_nxt = 8'd255 - qs; end
        2'd2:    begin r_nxt = qs;     g_nxt = 8'd255;      b_nxt = 8'd0; end
        default: begin r_nxt = 8'd255; g_nxt = 8'd255 - qs; b_nxt = 8'd0; end
      endcase
    end
  end

  // output register
  logic        out_valid_r;
  logic [31:0] ovx_r, ovy_r, opx_r, opy_r;
  logic [7:0]  or_r, og_r, ob_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= vh_r[DivSteps];
    ovx_r <= hvx_r[DivSteps]; ovy_r <= hvy_r[DivSteps];
    opx_r <= hpx_r[DivSteps]; opy_r <= hpy_r[DivSteps];
    or_r <= r_nxt; og_r <= g_nxt; ob_r <= b_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_new_vel_x   = ovx_r;
  assign out_new_vel_y   = ovy_r;
  assign out_new_pos_x   = opx_r;
  assign out_new_pos_y   = opy_r;
  assign out_color_red   = or_r;
  assign out_color_green = og_r;
  assign out_color_blue  = ob_r;

  // results never appear without an earlier transfer in flight
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vh_r[DivSteps])) else $error("result without item");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_color_red == 8'd255 || out_color_blue == 8'd255 ||
                   out_color_green == 8'd255)) else $error("ramp byte mix");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_new_pos_x[31] && !out_new_pos_y[31]) else $error("pos below zero");

endmodule

// ===== bench/boid_kinematic_integrate_top_tb.sv =====
`timescale 1ns / 1ps
module boid_kinematic_integrate_top_tb;
  import bki_pkg::*;

  typedef struct {
    logic signed [31:0] ax, ay, vx, vy, px, py;
  } agent_in_t;

  typedef struct {
    logic signed [31:0] vx, vy, px, py;
    logic [7:0]         red, green, blue;
  } agent_out_t;

  typedef struct {
    agent_in_t  stim;
    bit         typed;
    agent_out_t want;
  } vec_row_t;

  localparam int QuietLimit = 2000;  // above the pipeline depth plus a full idle burst
  localparam int SettleCycles = 300; // pipeline depth with margin
  localparam int PhaseItems = 100;
  localparam int NumPhases = 9;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_accel_x, in_accel_y, in_vel_x, in_vel_y, in_pos_x, in_pos_y;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [30:0]        cfg_data;
  logic               out_valid;
  logic signed [31:0] out_new_vel_x, out_new_vel_y, out_new_pos_x, out_new_pos_y;
  logic [7:0]         out_color_red, out_color_green, out_color_blue;

  // predictor copy of the register file
  logic [30:0] force_max_r, force_min_r, speed_max_r, world_w_r, world_h_r;
  logic [16:0] time_step_r;

  agent_out_t expected_agents[$];
  int         fail_count;
  int         quiet_cycles;
  bit         in_taken;

  boid_kinematic_integrate_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_accel_x     (in_accel_x),
    .in_accel_y     (in_accel_y),
    .in_vel_x       (in_vel_x),
    .in_vel_y       (in_vel_y),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_new_vel_x  (out_new_vel_x),
    .out_new_vel_y  (out_new_vel_y),
    .out_new_pos_x  (out_new_pos_x),
    .out_new_pos_y  (out_new_pos_y),
    .out_color_red  (out_color_red),
    .out_color_green(out_color_green),
    .out_color_blue (out_color_blue)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned len_sq(longint x, longint y);
    longint unsigned ux;
    longint unsigned uy;
    ux = x < 0 ? longint'(-x) : x;
    uy = y < 0 ? longint'(-y) : y;
    return ux * ux + uy * uy;
  endfunction

  // bitwise integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // rescale a vector to length lim when longer, truncating toward zero
  function automatic void limit_len(inout longint x, inout longint y,
                                    input longint unsigned lim);
    longint unsigned sq;
    longint unsigned len;
    sq = len_sq(x, y);
    if (sq > lim * lim) begin
      len = int_sqrt(sq);
      if (len == 0) begin
        x = 0;
        y = 0;
      end else begin
        x = x * longint'(lim) / longint'(len);
        y = y * longint'(lim) / longint'(len);
      end
    end
  endfunction

  function automatic longint sat_word(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // keep inside [0, edge), pulling back by the margin at the far edge
  function automatic longint world_clamp(longint p, longint unsigned edge_pos);
    if (p < 0) return 0;
    if (p >= longint'(edge_pos)) return edge_pos >= 66 ? longint'(edge_pos) - 66 : 0;
    return p;
  endfunction

  function automatic longint unsigned ramp_step(longint unsigned s, longint unsigned m,
                                                longint unsigned seg);
    longint unsigned num;
    longint unsigned base;
    longint unsigned q;
    num = 1020 * s;
    base = 255 * seg * m;
    if (num <= base) return 0;
    q = (num - base) / m;
    return q > 255 ? 255 : q;
  endfunction

  function automatic agent_out_t integrate_agent(agent_in_t a);
    longint ax, ay, vx, vy, px, py, dt;
    longint unsigned s, m, fmin, r, g, b;
    agent_out_t res;
    ax = a.ax; ay = a.ay; vx = a.vx; vy = a.vy; px = a.px; py = a.py;
    dt = time_step_r > 17'd65536 ? 65536 : longint'(time_step_r);
    m = speed_max_r;
    fmin = force_min_r;
    limit_len(ax, ay, force_max_r);
    if (len_sq(ax, ay) < fmin * fmin) begin
      ax = 0;
      ay = 0;
    end
    vx = sat_word(vx + ax * dt / 65536);
    vy = sat_word(vy + ay * dt / 65536);
    limit_len(vx, vy, m);
    px = world_clamp(px + vx * dt / 65536, world_w_r);
    py = world_clamp(py + vy * dt / 65536, world_h_r);
    s = int_sqrt(len_sq(vx, vy));
    // blue-cyan-green-yellow-red ramp over four quarters of full scale
    if (m == 0) begin
      r = 255; g = 0; b = 0;
    end else if (4 * s <= m) begin
      r = 0; g = ramp_step(s, m, 0); b = 255;
    end else if (2 * s <= m) begin
      r = 0; g = 255; b = 255 - ramp_step(s, m, 1);
    end else if (4 * s <= 3 * m) begin
      r = ramp_step(s, m, 2); g = 255; b = 0;
    end else begin
      r = 255; g = 255 - ramp_step(s, m, 3); b = 0;
    end
    res.vx = vx[31:0];
    res.vy = vy[31:0];
    res.px = px[31:0];
    res.py = py[31:0];
    res.red = r[7:0];
    res.green = g[7:0];
    res.blue = b[7:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  // mostly near center within span, sometimes full random or a 32-bit extreme
  function automatic logic signed [31:0] pick_field(longint center, longint unsigned span);
    int unsigned mode;
    longint v;
    mode = $urandom_range(0, 9);
    if (mode <= 1) return $urandom;
    if (mode == 2) begin
      case ($urandom_range(0, 4))
        0: return 32'sh7fffffff;
        1: return 32'sh80000000;
        2: return -32'sd1;
        3: return 32'sd1;
        default: return 32'sd0;
      endcase
    end
    v = center + longint'({$urandom, $urandom} % (2 * span + 1)) - longint'(span);
    v = sat_word(v);
    return v[31:0];
  endfunction

  function automatic agent_in_t random_agent();
    agent_in_t a;
    longint unsigned aspan;
    longint unsigned vspan;
    aspan = 2 * longint'(force_max_r) + 1000;
    vspan = 2 * longint'(speed_max_r) + 1000;
    a.ax = pick_field(0, aspan);
    a.ay = pick_field(0, aspan);
    a.vx = pick_field(0, vspan);
    a.vy = pick_field(0, vspan);
    a.px = pick_field(longint'(world_w_r) / 2, longint'(world_w_r) * 3 / 5 + 100);
    a.py = pick_field(longint'(world_h_r) / 2, longint'(world_h_r) * 3 / 5 + 100);
    return a;
  endfunction

  // register write while the pipeline is empty; predictor follows immediately
  task automatic write_reg(cfg_idx_t idx, logic [30:0] val);
    @(negedge clk);
    start = 1'b0;
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    case (idx)
      CFG_FORCE_MAX: force_max_r = val;
      CFG_FORCE_MIN: force_min_r = val;
      CFG_SPEED_MAX: speed_max_r = val;
      CFG_TIME_STEP: time_step_r = val[16:0];
      CFG_WORLD_W:   world_w_r = val;
      CFG_WORLD_H:   world_h_r = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_all(logic [30:0] fmax, logic [30:0] fmin, logic [30:0] smax,
                           logic [30:0] dt, logic [30:0] ww, logic [30:0] wh);
    write_reg(CFG_FORCE_MAX, fmax);
    write_reg(CFG_FORCE_MIN, fmin);
    write_reg(CFG_SPEED_MAX, smax);
    write_reg(CFG_TIME_STEP, dt);
    write_reg(CFG_WORLD_W, ww);
    write_reg(CFG_WORLD_H, wh);
  endtask

  // one input transfer, optionally preceded by an idle burst
  task automatic send_agent(agent_in_t a, bit typed, agent_out_t want, bit may_idle);
    int gap;
    agent_out_t item;
    if (may_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      repeat (gap) begin
        @(negedge clk);
        start = 1'b0;
      end
    end
    @(negedge clk);
    start = 1'b1;
    in_accel_x = a.ax;
    in_accel_y = a.ay;
    in_vel_x = a.vx;
    in_vel_y = a.vy;
    in_pos_x = a.px;
    in_pos_y = a.py;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (typed) item = want;
    else item = integrate_agent(a);
    expected_agents.insert(expected_agents.size(), item);
  endtask

  // wait for every expected result, then let the pipeline run dry
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (expected_agents.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- result checking

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    agent_out_t e;
    in_taken = start && !busy && rst_n;
    if (rst_n && out_valid) begin
      if (expected_agents.size() == 0) begin
        $error("unexpected result transfer");
        fail_count++;
      end else begin
        e = expected_agents.pop_front();
        check_field("new_vel_x", e.vx, out_new_vel_x);
        check_field("new_vel_y", e.vy, out_new_vel_y);
        check_field("new_pos_x", e.px, out_new_pos_x);
        check_field("new_pos_y", e.py, out_new_pos_y);
        check_field("color_red", e.red, out_color_red);
        check_field("color_green", e.green, out_color_green);
        check_field("color_blue", e.blue, out_color_blue);
      end
    end
    // watchdog: cycles without any transfer on either side
    if (in_taken || (rst_n && out_valid)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("** boid_kinematic_integrate_top: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------- test sequence

  vec_row_t   vec_rows[12];
  agent_out_t no_want;

  initial begin
    agent_in_t a;
    int idx;
    start = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_FORCE_MAX;
    cfg_data = '0;
    in_accel_x = '0; in_accel_y = '0;
    in_vel_x = '0; in_vel_y = '0;
    in_pos_x = '0; in_pos_y = '0;
    fail_count = 0;
    quiet_cycles = 0;
    no_want = '{default: '0};
    // registers after reset
    force_max_r = 31'd65536;
    force_min_r = 31'd0;
    speed_max_r = 31'd262144;
    time_step_r = 17'd1092;
    world_w_r = 31'd52428800;
    world_h_r = 31'd39321600;

    // directed vectors under reset settings; typed results where obvious
    // at rest in the origin: zero speed gives pure blue
    vec_rows[0] = '{'{0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 8'd0, 8'd0, 8'd255}};
    // negative position clamps to zero
    vec_rows[1] = '{'{0, 0, 0, 0, -5, -1}, 1'b1, '{0, 0, 0, 0, 8'd0, 8'd0, 8'd255}};
    // exactly on the far edge pulls back by the margin
    vec_rows[2] = '{'{0, 0, 0, 0, 52428800, 39321600}, 1'b1,
                    '{0, 0, 52428734, 39321534, 8'd0, 8'd0, 8'd255}};
    // largest position clamps the same way
    vec_rows[3] = '{'{0, 0, 0, 0, 32'sh7fffffff, 32'sh7fffffff}, 1'b1,
                    '{0, 0, 52428734, 39321534, 8'd0, 8'd0, 8'd255}};
    // speed exactly at the limit: kept, full red
    vec_rows[4] = '{'{0, 0, 262144, 0, 0, 0}, 1'b1,
                    '{262144, 0, 4368, 0, 8'd255, 8'd0, 8'd0}};
    // remaining rows go through the predictor
    vec_rows[5] = '{'{32'sh7fffffff, 32'sh7fffffff, 0, 0, 1000, 1000}, 1'b0, no_want};
    vec_rows[6] = '{'{32'sh80000000, 32'sh80000000, 0, 0, 1000, 1000}, 1'b0, no_want};
    vec_rows[7] = '{'{0, 0, 32'sh7fffffff, 32'sh80000000, 65536, 65536}, 1'b0, no_want};
    vec_rows[8] = '{'{32'sh7fffffff, 0, 32'sh7fffffff, 0, 0, 0}, 1'b0, no_want};
    vec_rows[9] = '{'{100, -100, 65536, 65536, 52428799, 39321599}, 1'b0, no_want};
    vec_rows[10] = '{'{-1, -1, -1, -1, -1, -1}, 1'b0, no_want};
    vec_rows[11] = '{'{65536, 0, 200000, 0, 1 << 20, 1 << 20}, 1'b0, no_want};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (idx = 0; idx < 12; idx++) begin
      send_agent(vec_rows[idx].stim, vec_rows[idx].typed, vec_rows[idx].want, 1'b0);
    end
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        // no acceleration allowed, top speed and world, full step
        0: write_all(31'd0, 31'd0, 31'h7fffffff, 31'd65536, 31'h7fffffff, 31'h7fffffff);
        // step above one, high force floor, tiny speed, world below the margin
        1: write_all(31'h7fffffff, 31'd1 << 20, 31'd1, 31'h1ffff, 31'd0, 31'd65);
        // zero speed limit, frozen time, world just at the margin
        2: write_all(31'h7fffffff, 31'd0, 31'd0, 31'd0, 31'd66, 31'd67);
        // floor at the top of its range drops every acceleration
        3: write_all(31'd1 << 18, 31'h7fffffff, 31'd1 << 20, 31'd65536, 31'd1 << 24,
                     31'd1 << 22);
        // back to reset values, no idling, for the closing stretch
        NumPhases - 1: write_all(31'd65536, 31'd0, 31'd262144, 31'd1092, 31'd52428800,
                                 31'd39321600);
        default: write_all(31'($urandom_range(0, 1 << 22)), 31'($urandom_range(0, 1 << 16)),
                           31'($urandom_range(1 << 10, 1 << 24)),
                           31'($urandom_range(0, 65536)),
                           31'($urandom_range(66, 1 << 28)),
                           31'($urandom_range(66, 1 << 28)));
      endcase
      for (int k = 0; k < PhaseItems; k++) begin
        a = random_agent();
        send_agent(a, 1'b0, no_want, p != NumPhases - 1);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("** boid_kinematic_integrate_top: PASSED **");
    end else begin
      $display("** boid_kinematic_integrate_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bki_pkg.sv
hw/rtl/bki_isqrt.sv
hw/rtl/bki_div.sv
hw/rtl/bki_clamp.sv
hw/rtl/boid_kinematic_integrate_top.sv
bench/boid_kinematic_integrate_top_tb.sv
